// ----- rtl/brd_pkg.sv -----
package brd_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int CFG_W           = 24;
    localparam int RLEN_W          = 24;
    localparam int HDR_W           = 4;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET  = 24'd65536;
    localparam logic [7:0]       TAG_SEQUENCE   = 8'h30;
    localparam logic [6:0]       LOW_SEVEN      = 7'h7f;
    localparam logic [2:0]       MAX_LEN_OCTETS = 3'd7;
    localparam int               MIN_TOTAL      = 16;
    localparam logic [HDR_W-1:0] SHORT_HDR      = 4'd2;

    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_END  = 1'b1
    } t_command;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_TAG      = 3'd1,
        ST_BAD_LEN_SIZE = 3'd2,
        ST_TOO_LARGE    = 3'd3,
        ST_TOO_SHORT    = 3'd4,
        ST_TRUNCATED    = 3'd5,
        ST_CLEAN_END    = 3'd6,
        ST_HALTED       = 3'd7
    } t_status;

    typedef enum logic [4:0] {
        PH_TAG       = 5'b00001,
        PH_LEN_FIRST = 5'b00010,
        PH_LEN_MORE  = 5'b00100,
        PH_BODY      = 5'b01000,
        PH_HALT      = 5'b10000
    } t_phase;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        byte_out;
        logic [2:0]        status;
        logic              record_start;
        logic              header_flag;
        logic              record_end;
        logic [RLEN_W-1:0] record_length;
    } t_out_item;

endpackage

// ----- rtl/brd_core.sv -----
module brd_core #(
    parameter int LENGTH_BITS = brd_pkg::LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  brd_pkg::t_in_item         i_item,
    input  logic [brd_pkg::CFG_W-1:0] i_max,
    output brd_pkg::t_out_item        o_result
);

    localparam int CMP_W = (LENGTH_BITS > brd_pkg::CFG_W) ? LENGTH_BITS : brd_pkg::CFG_W;

    brd_pkg::t_phase         r_phase, n_phase;
    logic [LENGTH_BITS-1:0]  r_acc, n_acc;
    logic                    r_ovf, n_ovf;
    logic [2:0]              r_left, n_left;
    logic [2:0]              r_count, n_count;
    logic [LENGTH_BITS-1:0]  r_remain, n_remain;
    logic [LENGTH_BITS-1:0]  r_total, n_total;

    logic                    cmd_end;
    logic [7:0]              b;
    logic                    j_active;
    logic [LENGTH_BITS-1:0]  j_total;
    logic                    j_ovf;
    logic [brd_pkg::HDR_W-1:0] j_hdr;
    logic                    j_large;
    logic                    j_short;
    logic [LENGTH_BITS:0]    long_sum;
    logic [brd_pkg::HDR_W-1:0] long_hdr;
    logic [LENGTH_BITS-1:0]  acc_step;
    logic                    ovf_step;
    logic [2:0]              left_dec;
    logic [LENGTH_BITS-1:0]  remain_dec;
    logic [CMP_W-1:0]        total_wide;
    brd_pkg::t_status        st;
    logic                    hdr_flag;
    logic                    start_flag;
    logic                    end_flag;

    assign cmd_end = (i_item.command == brd_pkg::CMD_END);
    assign b       = i_item.data_byte;

    always_comb begin
        if (!r_ovf && (r_acc[LENGTH_BITS-1 -: 8] != 8'd0)) begin
            acc_step = '1;
            ovf_step = 1'b1;
        end else if (!r_ovf) begin
            acc_step = {r_acc[LENGTH_BITS-9:0], b};
            ovf_step = 1'b0;
        end else begin
            acc_step = r_acc;
            ovf_step = 1'b1;
        end
        left_dec   = r_left - 3'd1;
        long_hdr   = brd_pkg::HDR_W'(r_count) + brd_pkg::HDR_W'(2);
        long_sum   = {1'b0, acc_step} + (LENGTH_BITS + 1)'(long_hdr);
        remain_dec = r_remain - LENGTH_BITS'(1);
    end

    always_comb begin
        j_active = 1'b0;
        j_total  = LENGTH_BITS'(2);
        j_ovf    = 1'b0;
        j_hdr    = brd_pkg::SHORT_HDR;
        if (r_phase == brd_pkg::PH_LEN_FIRST) begin
            if (!b[7]) begin
                j_active = 1'b1;
                j_total  = LENGTH_BITS'(b[6:0]) + LENGTH_BITS'(2);
            end else if (b[6:0] == 7'd0) begin
                j_active = 1'b1;
            end
        end else if (r_phase == brd_pkg::PH_LEN_MORE) begin
            j_active = (left_dec == 3'd0);
            j_total  = long_sum[LENGTH_BITS-1:0];
            j_ovf    = ovf_step | long_sum[LENGTH_BITS];
            j_hdr    = long_hdr;
        end
        j_large = j_ovf || (CMP_W'(j_total) >= CMP_W'(i_max));
        j_short = (j_total <= LENGTH_BITS'(brd_pkg::MIN_TOTAL));
    end

    always_comb begin
        n_phase    = r_phase;
        n_acc      = r_acc;
        n_ovf      = r_ovf;
        n_left     = r_left;
        n_count    = r_count;
        n_remain   = r_remain;
        n_total    = r_total;
        st         = brd_pkg::ST_OK;
        hdr_flag   = 1'b0;
        start_flag = 1'b0;
        end_flag   = 1'b0;

        if (r_phase == brd_pkg::PH_HALT) begin
            st = brd_pkg::ST_HALTED;
        end else if (cmd_end) begin
            if (r_phase == brd_pkg::PH_TAG) begin
                st = brd_pkg::ST_CLEAN_END;
            end else begin
                st      = brd_pkg::ST_TRUNCATED;
                n_phase = brd_pkg::PH_HALT;
            end
        end else begin
            case (r_phase)
                brd_pkg::PH_TAG: begin
                    if (b != brd_pkg::TAG_SEQUENCE) begin
                        st      = brd_pkg::ST_BAD_TAG;
                        n_phase = brd_pkg::PH_HALT;
                    end else begin
                        start_flag = 1'b1;
                        hdr_flag   = 1'b1;
                        n_phase    = brd_pkg::PH_LEN_FIRST;
                    end
                end
                brd_pkg::PH_LEN_FIRST: begin
                    if (b[7] && (b[6:0] > 7'(brd_pkg::MAX_LEN_OCTETS))) begin
                        st      = brd_pkg::ST_BAD_LEN_SIZE;
                        n_phase = brd_pkg::PH_HALT;
                    end else if (!j_active) begin
                        hdr_flag = 1'b1;
                        n_left   = b[2:0];
                        n_count  = b[2:0];
                        n_acc    = '0;
                        n_ovf    = 1'b0;
                        n_phase  = brd_pkg::PH_LEN_MORE;
                    end
                end
                brd_pkg::PH_LEN_MORE: begin
                    n_acc  = acc_step;
                    n_ovf  = ovf_step;
                    n_left = left_dec;
                    if (!j_active) begin
                        hdr_flag = 1'b1;
                    end else begin
                        n_ovf = j_ovf;
                    end
                end
                brd_pkg::PH_BODY: begin
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        end_flag = 1'b1;
                        n_phase  = brd_pkg::PH_TAG;
                    end
                end
                default: begin
                    st      = brd_pkg::ST_HALTED;
                    n_phase = brd_pkg::PH_HALT;
                end
            endcase

            if (j_active) begin
                if (j_large) begin
                    st      = brd_pkg::ST_TOO_LARGE;
                    n_phase = brd_pkg::PH_HALT;
                end else if (j_short) begin
                    st      = brd_pkg::ST_TOO_SHORT;
                    n_phase = brd_pkg::PH_HALT;
                end else begin
                    hdr_flag = 1'b1;
                    n_total  = j_total;
                    n_remain = j_total - LENGTH_BITS'(j_hdr);
                    n_phase  = brd_pkg::PH_BODY;
                end
            end
        end
    end

    assign total_wide = CMP_W'(r_total);

    always_comb begin
        o_result.byte_out      = cmd_end ? 8'd0 : b;
        o_result.status        = st;
        o_result.record_start  = start_flag;
        o_result.header_flag   = hdr_flag;
        o_result.record_end    = end_flag;
        o_result.record_length = end_flag ? total_wide[brd_pkg::RLEN_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= brd_pkg::PH_TAG;
            r_acc    <= '0;
            r_ovf    <= 1'b0;
            r_left   <= '0;
            r_count  <= '0;
            r_remain <= '0;
            r_total  <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_ovf    <= n_ovf;
            r_left   <= n_left;
            r_count  <= n_count;
            r_remain <= n_remain;
            r_total  <= n_total;
        end
    end

endmodule

// ----- rtl/ber_record_deframer.sv -----
// A beat accepted into the input register is framed by the core and written into the output
// register, which presents it on the output.
// Throughput: one beat per cycle; the input register and the output register each
// advance whenever the output register is empty or its beat is taken.
// Reset is synchronous and active low; it returns the framing state to expect a tag
// byte, empties both registers and loads the maximum record length of 65536.
module ber_record_deframer #(
    parameter int LENGTH_BITS = brd_pkg::LENGTH_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  brd_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output brd_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [brd_pkg::CFG_W-1:0] i_cfg_data
);

    logic                      r_in_valid;
    brd_pkg::t_in_item         r_in_data;
    logic                      r_out_valid;
    brd_pkg::t_out_item        r_out_data;
    logic [brd_pkg::CFG_W-1:0] r_max;
    logic                      out_adv;
    logic                      fire;
    logic                      in_take;
    brd_pkg::t_out_item        result;

    assign out_adv     = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && out_adv;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_in_stall  = r_in_valid && !out_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_cfg_ready = 1'b1;

    brd_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in_data),
        .i_max   (r_max),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_max       <= brd_pkg::MAX_LEN_RESET;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in_data;
        end
        if (fire) begin
            r_out_data <= result;
        end
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import brd_pkg::*;

    localparam int LEN_W       = LENGTH_BITS_DEF;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_CYCLES = 64;
    localparam int MAX_SHOWN   = 10;

    typedef enum int {
        FAULT_BAD_TAG,
        FAULT_LEN_SIZE,
        FAULT_TOO_LARGE,
        FAULT_TOO_SHORT,
        FAULT_TRUNCATED,
        FAULT_ZERO_OCTETS,
        FAULT_ACC_OVERFLOW,
        FAULT_SUM_OVERFLOW
    } t_fault;

    class framing_tracker;
        t_phase            phase;
        logic [CFG_W-1:0]  max_len;
        logic [LEN_W-1:0]  acc;
        logic [LEN_W-1:0]  remaining;
        logic [LEN_W-1:0]  rec_total;
        bit                ovf;
        logic [2:0]        octs_left;
        logic [2:0]        oct_count;
        t_out_item         framed_beats[$];
        int                mismatches;
        int                beats;
        int                records;
        int                end_markers;

        function new();
            phase       = PH_TAG;
            max_len     = MAX_LEN_RESET;
            acc         = '0;
            remaining   = '0;
            rec_total   = '0;
            ovf         = 1'b0;
            octs_left   = '0;
            oct_count   = '0;
            mismatches  = 0;
            beats       = 0;
            records     = 0;
            end_markers = 0;
        endfunction

        function t_status judge(logic [LEN_W-1:0] total, bit too_big, logic [HDR_W-1:0] hdr);
            if (too_big || total >= max_len) begin
                phase = PH_HALT;
                return ST_TOO_LARGE;
            end
            if (total <= MIN_TOTAL) begin
                phase = PH_HALT;
                return ST_TOO_SHORT;
            end
            rec_total = total;
            remaining = total - hdr;
            phase     = PH_BODY;
            return ST_OK;
        endfunction

        function void note_byte(t_in_item it);
            t_out_item         r;
            t_status           st;
            logic [7:0]        b;
            logic [HDR_W-1:0]  hdr;
            logic [LEN_W:0]    sum;
            b          = it.data_byte;
            r          = '0;
            r.byte_out = (it.command == CMD_END) ? 8'h00 : b;
            if (it.command == CMD_END) begin
                end_markers++;
            end
            if (phase == PH_HALT) begin
                r.status = ST_HALTED;
            end else if (it.command == CMD_END) begin
                if (phase == PH_TAG) begin
                    r.status = ST_CLEAN_END;
                end else begin
                    phase    = PH_HALT;
                    r.status = ST_TRUNCATED;
                end
            end else begin
                case (phase)
                    PH_TAG: begin
                        if (b != TAG_SEQUENCE) begin
                            phase    = PH_HALT;
                            r.status = ST_BAD_TAG;
                        end else begin
                            phase          = PH_LEN_FIRST;
                            r.record_start = 1'b1;
                            r.header_flag  = 1'b1;
                        end
                    end
                    PH_LEN_FIRST: begin
                        if (!b[7]) begin
                            st = judge(LEN_W'(b[6:0] & LOW_SEVEN) + SHORT_HDR, 1'b0, SHORT_HDR);
                        end else if (b[6:0] > {4'd0, MAX_LEN_OCTETS}) begin
                            phase = PH_HALT;
                            st    = ST_BAD_LEN_SIZE;
                        end else if (b[6:0] == 7'd0) begin
                            st = judge(LEN_W'(SHORT_HDR), 1'b0, SHORT_HDR);
                        end else begin
                            octs_left = b[2:0];
                            oct_count = b[2:0];
                            acc       = '0;
                            ovf       = 1'b0;
                            phase     = PH_LEN_MORE;
                            st        = ST_OK;
                        end
                        r.status      = st;
                        r.header_flag = (st == ST_OK);
                    end
                    PH_LEN_MORE: begin
                        if (!ovf) begin
                            if (acc[LEN_W-1 -: 8] != 8'd0) begin
                                ovf = 1'b1;
                                acc = '1;
                            end else begin
                                acc = {acc[LEN_W-9:0], b};
                            end
                        end
                        octs_left = octs_left - 3'd1;
                        if (octs_left == 3'd0) begin
                            hdr = HDR_W'(oct_count) + SHORT_HDR;
                            sum = {1'b0, acc} + hdr;
                            if (sum[LEN_W]) begin
                                ovf = 1'b1;
                            end
                            st = judge(sum[LEN_W-1:0], ovf, hdr);
                        end else begin
                            st = ST_OK;
                        end
                        r.status      = st;
                        r.header_flag = (st == ST_OK);
                    end
                    default: begin
                        remaining = remaining - 1'b1;
                        if (remaining == '0) begin
                            phase           = PH_TAG;
                            r.record_end    = 1'b1;
                            r.record_length = rec_total;
                            records++;
                        end
                    end
                endcase
            end
            framed_beats.push_back(r);
        endfunction

        function string show(t_out_item r);
            return $sformatf("byte %02h status %0d start %b header %b end %b length %0d",
                r.byte_out, r.status, r.record_start, r.header_flag, r.record_end,
                r.record_length);
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            beats++;
            if (framed_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("Beat %0d arrived with nothing pending: %s", beats, show(got));
                end
                return;
            end
            want = framed_beats.pop_front();
            if (got.byte_out !== want.byte_out || got.status !== want.status ||
                got.record_start !== want.record_start ||
                got.header_flag !== want.header_flag ||
                got.record_end !== want.record_end ||
                got.record_length !== want.record_length) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("Beat %0d mismatch: expected %s", beats, show(want));
                    $display("Beat %0d mismatch: actual   %s", beats, show(got));
                end
            end
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    framing_tracker   sb;
    bit               idle_on      = 1'b1;
    bit               hold_request = 1'b0;
    int               items_sent   = 0;
    int               cycles       = 0;
    logic [CFG_W-1:0] mid_limit;
    t_fault           closing_fault;

    ber_record_deframer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles.", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_beat(o_out_data);
        end
    end

    initial begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && run_left == 0 && idle_on) begin
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = $urandom_range(1, 8);
                end else begin
                    run_left = $urandom_range(1, 12);
                end
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end
            end
        end
    end

    task automatic send_item(t_command cmd, logic [7:0] b);
        t_in_item it;
        int       gap;
        it.command   = cmd;
        it.data_byte = b;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_byte(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.framed_beats.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_max_length(logic [CFG_W-1:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.max_len = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A zero octet count selects the short form; otherwise the body length is
    // sent big-endian in that many octets, padded with leading zeros.
    task automatic send_record(int body_len, int octets);
        int i;
        send_item(CMD_DATA, TAG_SEQUENCE);
        if (octets == 0) begin
            send_item(CMD_DATA, 8'(body_len));
        end else begin
            send_item(CMD_DATA, {1'b1, 7'(octets)});
            for (i = octets - 1; i >= 0; i--) begin
                send_item(CMD_DATA, (i < 4) ? 8'(body_len >> (8 * i)) : 8'h00);
            end
        end
        for (i = 0; i < body_len; i++) begin
            send_item(CMD_DATA, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_record(int max_total);
        int octets;
        int hdr;
        int body_min;
        int body_cap;
        int body_len;
        octets   = ($urandom_range(0, 7) < 3) ? 0 : $urandom_range(1, 7);
        hdr      = (octets == 0) ? 2 : octets + 2;
        body_min = MIN_TOTAL + 1 - hdr;
        body_cap = max_total - hdr - 1;
        if (body_cap > 300) begin
            body_cap = 300;
        end
        if (octets == 0 && body_cap > 127) begin
            body_cap = 127;
        end
        if (octets == 1 && body_cap > 255) begin
            body_cap = 255;
        end
        if ($urandom_range(0, 9) == 0) begin
            body_len = $urandom_range(body_min, body_cap);
        end else begin
            body_len = $urandom_range(body_min, body_min + 24);
        end
        send_record(body_len, octets);
        if ($urandom_range(0, 5) == 0) begin
            send_item(CMD_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_fault_case(t_fault kind);
        int         cut;
        int         i;
        int         limit;
        logic [7:0] b;
        case (kind)
            FAULT_BAD_TAG: begin
                b = 8'($urandom_range(0, 255));
                if (b == TAG_SEQUENCE) begin
                    b = ~b;
                end
                send_item(CMD_DATA, b);
            end
            FAULT_LEN_SIZE: begin
                send_item(CMD_DATA, TAG_SEQUENCE);
                send_item(CMD_DATA, {1'b1, 7'($urandom_range(8, 127))});
            end
            FAULT_TOO_LARGE: begin
                limit = ($urandom_range(0, 1) == 0) ? MIN_TOTAL + 1 : $urandom_range(18, 128);
                write_max_length(CFG_W'(limit));
                send_item(CMD_DATA, TAG_SEQUENCE);
                send_item(CMD_DATA, 8'($urandom_range(limit - 2, 127)));
            end
            FAULT_TOO_SHORT: begin
                send_item(CMD_DATA, TAG_SEQUENCE);
                send_item(CMD_DATA, 8'($urandom_range(0, 14)));
            end
            FAULT_TRUNCATED: begin
                // The record would be a tag, 0x83, a body length of 20 in three
                // octets, then 20 body bytes; it is cut short at a random point.
                cut = $urandom_range(1, 24);
                for (i = 0; i < cut; i++) begin
                    if (i == 0) begin
                        b = TAG_SEQUENCE;
                    end else if (i == 1) begin
                        b = 8'h83;
                    end else if (i < 4) begin
                        b = 8'h00;
                    end else if (i == 4) begin
                        b = 8'd20;
                    end else begin
                        b = 8'($urandom_range(0, 255));
                    end
                    send_item(CMD_DATA, b);
                end
                send_item(CMD_END, 8'($urandom_range(0, 255)));
            end
            FAULT_ZERO_OCTETS: begin
                if ($urandom_range(0, 1) == 0) begin
                    write_max_length(CFG_W'($urandom_range(0, 2)));
                end
                send_item(CMD_DATA, TAG_SEQUENCE);
                send_item(CMD_DATA, 8'h80);
            end
            FAULT_ACC_OVERFLOW: begin
                limit = $urandom_range(4, 7);
                send_item(CMD_DATA, TAG_SEQUENCE);
                send_item(CMD_DATA, {1'b1, 7'(limit)});
                send_item(CMD_DATA, 8'($urandom_range(1, 255)));
                for (i = 1; i < limit; i++) begin
                    send_item(CMD_DATA, 8'($urandom_range(0, 255)));
                end
            end
            default: begin
                send_item(CMD_DATA, TAG_SEQUENCE);
                send_item(CMD_DATA, 8'h83);
                send_item(CMD_DATA, 8'hff);
                send_item(CMD_DATA, 8'hff);
                send_item(CMD_DATA, 8'($urandom_range(8'hfb, 8'hff)));
            end
        endcase
    endtask

    initial begin
        int i;
        int random_start;
        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(CMD_END, 8'hff);
        send_record(MIN_TOTAL + 1 - 2, 0);
        send_record(MIN_TOTAL + 1 - 9, 7);
        send_item(CMD_END, 8'h00);

        write_max_length('1);
        random_start = items_sent;
        while (items_sent - random_start < 220) begin
            if (items_sent - random_start > 100 && items_sent - random_start < 140) begin
                hold_request = 1'b1;
            end
            send_random_record(int'(sb.max_len));
        end

        // The first record here sits exactly one byte under the new limit.
        mid_limit = CFG_W'($urandom_range(60, 400));
        write_max_length(mid_limit);
        send_record(int'(mid_limit) - 1 - 4, 2);
        while (items_sent - random_start < 400) begin
            if (items_sent - random_start > 320) begin
                idle_on = 1'b0;
            end
            send_random_record(int'(mid_limit));
        end
        idle_on = 1'b0;

        drain_results();
        closing_fault = t_fault'($urandom_range(FAULT_BAD_TAG, FAULT_SUM_OVERFLOW));
        send_fault_case(closing_fault);
        for (i = 0; i < 10; i++) begin
            send_item(($urandom_range(0, 3) == 0) ? CMD_END : CMD_DATA,
                8'($urandom_range(0, 255)));
        end
        drain_results();
        repeat (4) @(posedge i_clk);

        $display("Checked %0d output beats: %0d complete records and %0d end markers.",
            sb.beats, sb.records, sb.end_markers);
        $display("Limits used: 65536, 16777215 and %0d; closing fault %s.",
            mid_limit, closing_fault.name());
        if (sb.mismatches == 0 && sb.framed_beats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
